// ----- rtl/tkf_pkg.sv -----
// Shared types and constants for the tilt angle Kalman filter unit.
// No dependencies; compiled first.
package tkf_pkg;

	localparam int DATA_W   = 32;
	localparam int CFG_W    = 31;
	localparam int CFG_IDX_W = 2;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CFG_W-1:0]         cfg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIME_STEP     = 2'd0,
		CFG_MEASURE_NOISE = 2'd1,
		CFG_GYRO_NOISE    = 2'd2,
		CFG_ANGLE_NOISE   = 2'd3
	} cfg_reg_t;

	// Q8.24 reset values
	localparam cfg_t  DT_RESET = 31'd335544;
	localparam cfg_t  R_RESET  = 31'd5033165;
	localparam cfg_t  QG_RESET = 31'd50332;
	localparam cfg_t  QA_RESET = 31'd16777;
	localparam data_t ONE_Q24  = 32'sd16777216;

endpackage

// ----- rtl/tkf_in_if.sv -----
// Input channel of the tilt angle Kalman filter: one gyro sample per transaction.
// Depends on tkf_pkg.
interface tkf_in_if;
	logic                valid;
	logic                ready;
	tkf_pkg::data_t      gyro_sample;
	tkf_pkg::data_t      measured_angle;
	logic                has_measurement;

	modport source(output valid, gyro_sample, measured_angle, has_measurement, input ready);
	modport sink(input valid, gyro_sample, measured_angle, has_measurement, output ready);
endinterface

// ----- rtl/tkf_out_if.sv -----
// Output channel of the tilt angle Kalman filter: one estimate per transaction.
// Depends on tkf_pkg.
interface tkf_out_if;
	logic                valid;
	logic                ready;
	tkf_pkg::data_t      angle_estimate;
	tkf_pkg::data_t      unbiased_rate;

	modport source(output valid, angle_estimate, unbiased_rate, input ready);
	modport sink(input valid, angle_estimate, unbiased_rate, output ready);
endinterface

// ----- rtl/tilt_angle_kalman_filter_unit.sv -----
// Tilt angle Kalman filter unit, two states (angle, gyro bias), fixed point.
// A new sample is accepted only in the idle state, so an item must finish before the next is
// taken. The two gain divisions of an update run at 2 quotient bits per cycle, and all
// products go through the single shared multiplier.
// Reset: async active low; state to zero bias/angle, unit covariance, default config.
// Depends on tkf_pkg, tkf_in_if, tkf_out_if.
module tilt_angle_kalman_filter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tkf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  tkf_pkg::cfg_t                     cfg_data,
	tkf_in_if.sink                            samples,
	tkf_out_if.source                         results
);

	localparam int DivBitsPerCycle = 2;
	localparam int DivSteps        = tkf_pkg::DATA_W / DivBitsPerCycle;
	localparam int DivCntW         = $clog2(DivSteps);
	localparam int PredOps         = 4;
	localparam int UpdOps          = 6;

	localparam logic signed [42:0] SatMax = 43'sd2147483647;
	localparam logic signed [42:0] SatMin = -43'sd2147483648;
	localparam tkf_pkg::data_t     DataMax = 32'sh7fffffff;
	localparam tkf_pkg::data_t     DataMin = 32'sh80000000;
	localparam logic signed [64:0] RndHalf = 65'sd8388608;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRED,
		ST_CHECK,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_DIV_STORE,
		ST_UPD,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		DST_ANG,
		DST_BIAS,
		DST_PAA,
		DST_PAB,
		DST_PBA,
		DST_PBB,
		DST_PAB_PBA
	} dst_t;

	function automatic tkf_pkg::data_t sat32(input logic signed [42:0] v);
		if (v > SatMax) return DataMax;
		if (v < SatMin) return DataMin;
		return tkf_pkg::data_t'(v[31:0]);
	endfunction

	function automatic tkf_pkg::data_t acc_sat(input tkf_pkg::data_t base,
			input logic signed [40:0] r, input logic sub);
		logic signed [42:0] s;
		s = sub ? (43'(base) - 43'(r)) : (43'(base) + 43'(r));
		return sat32(s);
	endfunction

	// configuration
	tkf_pkg::cfg_t dt_q, r_q, qg_q, qa_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= tkf_pkg::DT_RESET;
			r_q  <= tkf_pkg::R_RESET;
			qg_q <= tkf_pkg::QG_RESET;
			qa_q <= tkf_pkg::QA_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tkf_pkg::CFG_TIME_STEP:     dt_q <= cfg_data;
				tkf_pkg::CFG_MEASURE_NOISE: r_q  <= cfg_data;
				tkf_pkg::CFG_GYRO_NOISE:    qg_q <= cfg_data;
				tkf_pkg::CFG_ANGLE_NOISE:   qa_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// filter state and sequencer registers
	state_t                   state_q;
	logic [2:0]               step_q;
	tkf_pkg::data_t           ang_q, bias_q, paa_q, pab_q, pba_q, pbb_q;
	tkf_pkg::data_t           rate_q, meas_q, d00_q, err_q, k0_q, k1_q;
	logic                     has_q;
	logic [31:0]              e_q;

	// divider
	logic [31:0]              div_rem_q, div_num_q, div_quo_q;
	logic [DivCntW-1:0]       div_cnt_q;
	logic                     div_ovf_q, div_neg_q, div_sel_q;

	// multiplier writeback stage
	logic                     wb_vld_s1, wb_sub_s1;
	dst_t                     wb_dst_s1;
	logic signed [64:0]       prod_s1;

	// output register
	logic                     out_vld_q;
	tkf_pkg::data_t           out_ang_q, out_rate_q;

	// operand select for the shared multiplier
	logic signed [32:0]       mul_a;
	tkf_pkg::data_t           mul_b;
	dst_t                     mul_dst;
	logic                     mul_sub;
	logic signed [64:0]       prod_w;

	always_comb begin
		mul_a   = 33'(rate_q);
		mul_b   = tkf_pkg::data_t'({1'b0, dt_q});
		mul_dst = DST_ANG;
		mul_sub = 1'b0;
		if (state_q == ST_PRED) begin
			unique case (step_q)
				3'd0: begin mul_a = 33'(rate_q); mul_dst = DST_ANG; end
				3'd1: begin mul_a = 33'(d00_q); mul_dst = DST_PAA; end
				3'd2: begin mul_a = -33'(pbb_q); mul_dst = DST_PAB_PBA; end
				default: begin mul_a = $signed({2'b00, qg_q}); mul_dst = DST_PBB; end
			endcase
		end else begin
			mul_sub = 1'b1;
			unique case (step_q)
				3'd0: begin mul_a = 33'(k1_q); mul_b = paa_q; mul_dst = DST_PBA; end
				3'd1: begin mul_a = 33'(k1_q); mul_b = pab_q; mul_dst = DST_PBB; end
				3'd2: begin
					mul_a = 33'(k1_q); mul_b = err_q; mul_dst = DST_BIAS; mul_sub = 1'b0;
				end
				3'd3: begin mul_a = 33'(k0_q); mul_b = paa_q; mul_dst = DST_PAA; end
				3'd4: begin mul_a = 33'(k0_q); mul_b = pab_q; mul_dst = DST_PAB; end
				default: begin
					mul_a = 33'(k0_q); mul_b = err_q; mul_dst = DST_ANG; mul_sub = 1'b0;
				end
			endcase
		end
	end

	assign prod_w = 65'(mul_a) * 65'(mul_b);

	// rounded product: floor((p + 2^23) / 2^24)
	logic signed [64:0]       rnd_w;
	logic signed [40:0]       rq_w;
	assign rnd_w = prod_s1 + RndHalf;
	assign rq_w  = rnd_w[64:24];

	// innovation variance and dividend setup
	logic signed [32:0]       e_w;
	logic                     e_pos;
	tkf_pkg::data_t           div_p;
	logic [32:0]              div_negp;
	logic [31:0]              div_mag;
	logic [56:0]              div_num57;

	assign e_w       = 33'(paa_q) + $signed({2'b00, r_q});
	assign e_pos     = !e_w[32] && (e_w != 33'sd0);
	assign div_p     = div_sel_q ? pba_q : paa_q;
	assign div_negp  = 33'd0 - 33'(div_p);
	assign div_mag   = div_p[31] ? div_negp[31:0] : div_p[31:0];
	assign div_num57 = {1'b0, div_mag, 24'd0} + {26'd0, e_q[31:1]};

	// radix-4 restoring division step
	logic [31:0]              rem_nx, num_nx, quo_nx;

	always_comb begin
		logic [32:0] t;
		rem_nx = div_rem_q;
		num_nx = div_num_q;
		quo_nx = div_quo_q;
		for (int i = 0; i < DivBitsPerCycle; i++) begin
			t      = {rem_nx, num_nx[31]};
			num_nx = {num_nx[30:0], 1'b0};
			if (t >= {1'b0, e_q}) begin
				t      = t - {1'b0, e_q};
				quo_nx = {quo_nx[30:0], 1'b1};
			end else begin
				quo_nx = {quo_nx[30:0], 1'b0};
			end
			rem_nx = t[31:0];
		end
	end

	tkf_pkg::data_t           gain_w;
	logic                     gain_big;
	assign gain_big = div_ovf_q || div_quo_q[31];
	assign gain_w   = div_neg_q ? (gain_big ? DataMin : tkf_pkg::data_t'(-div_quo_q))
	                            : (gain_big ? DataMax : tkf_pkg::data_t'(div_quo_q));

	assign samples.ready          = (state_q == ST_IDLE);
	assign results.valid          = out_vld_q;
	assign results.angle_estimate = out_ang_q;
	assign results.unbiased_rate  = out_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			ang_q      <= '0;
			bias_q     <= '0;
			paa_q      <= tkf_pkg::ONE_Q24;
			pab_q      <= '0;
			pba_q      <= '0;
			pbb_q      <= tkf_pkg::ONE_Q24;
			wb_vld_s1  <= 1'b0;
			out_vld_q  <= 1'b0;
			div_cnt_q  <= '0;
			div_sel_q  <= 1'b0;
		end else begin
			// multiplier issue and writeback
			wb_vld_s1 <= (state_q == ST_PRED) || (state_q == ST_UPD);
			prod_s1   <= prod_w;
			wb_dst_s1 <= mul_dst;
			wb_sub_s1 <= mul_sub;
			if (wb_vld_s1) begin
				unique case (wb_dst_s1)
					DST_ANG:  ang_q  <= acc_sat(ang_q, rq_w, wb_sub_s1);
					DST_BIAS: bias_q <= acc_sat(bias_q, rq_w, wb_sub_s1);
					DST_PAA:  paa_q  <= acc_sat(paa_q, rq_w, wb_sub_s1);
					DST_PAB:  pab_q  <= acc_sat(pab_q, rq_w, wb_sub_s1);
					DST_PBA:  pba_q  <= acc_sat(pba_q, rq_w, wb_sub_s1);
					DST_PBB:  pbb_q  <= acc_sat(pbb_q, rq_w, wb_sub_s1);
					DST_PAB_PBA: begin
						pab_q <= acc_sat(pab_q, rq_w, wb_sub_s1);
						pba_q <= acc_sat(pba_q, rq_w, wb_sub_s1);
					end
					default: ;
				endcase
			end

			// in ST_DONE the output register is reloaded instead
			if (results.valid && results.ready && (state_q != ST_DONE)) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						rate_q  <= sat32(43'(samples.gyro_sample) - 43'(bias_q));
						d00_q   <= sat32($signed({12'd0, qa_q}) - 43'(pab_q) - 43'(pba_q));
						meas_q  <= samples.measured_angle;
						has_q   <= samples.has_measurement;
						step_q  <= '0;
						state_q <= ST_PRED;
					end
				end
				ST_PRED: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'(PredOps - 1)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					e_q       <= e_w[31:0];
					err_q     <= sat32(43'(meas_q) - 43'(ang_q));
					div_sel_q <= 1'b0;
					state_q   <= (has_q && e_pos) ? ST_DIV_LOAD : ST_DONE;
				end
				ST_DIV_LOAD: begin
					div_neg_q <= div_p[31];
					div_ovf_q <= {7'd0, div_num57[56:32]} >= e_q;
					div_rem_q <= {7'd0, div_num57[56:32]};
					div_num_q <= div_num57[31:0];
					div_quo_q <= '0;
					div_cnt_q <= '0;
					state_q   <= ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					div_rem_q <= rem_nx;
					div_num_q <= num_nx;
					div_quo_q <= quo_nx;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
						state_q <= ST_DIV_STORE;
					end
				end
				ST_DIV_STORE: begin
					if (div_sel_q) begin
						k1_q    <= gain_w;
						step_q  <= '0;
						state_q <= ST_UPD;
					end else begin
						k0_q      <= gain_w;
						div_sel_q <= 1'b1;
						state_q   <= ST_DIV_LOAD;
					end
				end
				ST_UPD: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'(UpdOps - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_vld_q || results.ready) begin
						out_ang_q  <= ang_q;
						out_rate_q <= rate_q;
						out_vld_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- tb/sv/tilt_angle_kalman_filter_unit_checker.sv -----
// Checker for the tilt angle Kalman filter unit: tracks config writes, predicts each
// estimate from accepted samples and compares results in order.
// Depends on tkf_pkg, tkf_in_if, tkf_out_if.
module tilt_angle_kalman_filter_unit_checker
	import tkf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  cfg_t                 cfg_data,
	tkf_in_if                    samples,
	tkf_out_if                   results,
	output int                   fail_count,
	output int                   estimates_owed
);

	typedef struct packed {
		data_t angle_estimate;
		data_t unbiased_rate;
	} estimate_t;

	estimate_t expected_estimates[$];

	cfg_t   dt_cfg, r_cfg, qg_cfg, qa_cfg;
	longint angle_q, bias_q, p_aa, p_ab, p_ba, p_bb;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// floor((x + 2^23) / 2^24)
	function automatic longint rnd24(input longint x);
		return (x + 64'sd8388608) >>> 24;
	endfunction

	// (p << 24) / e, rounded half away from zero, e > 0
	function automatic longint gain_q24(input longint p, input longint e);
		logic neg;
		longint unsigned mag, q, eu;
		neg = p < 0;
		mag = neg ? longint'(-p) : longint'(p);
		mag = mag << 24;
		eu = e;
		q = (mag + eu / 2) / eu;
		if (q > 64'd2147483648)
			q = 64'd2147483648;
		return clamp32(neg ? -longint'(q) : longint'(q));
	endfunction

	task automatic filter_step(input data_t gyro, input data_t meas, input logic has,
			output estimate_t est);
		longint dt, rate, d00, d01, d11, e, err, k0, k1, t0, t1;
		dt = longint'(dt_cfg);
		rate = clamp32(longint'(gyro) - bias_q);
		angle_q = clamp32(angle_q + rnd24(rate * dt));
		d00 = clamp32(longint'(qa_cfg) - p_ab - p_ba);
		d01 = -p_bb;
		d11 = longint'(qg_cfg);
		p_aa = clamp32(p_aa + rnd24(d00 * dt));
		p_ab = clamp32(p_ab + rnd24(d01 * dt));
		p_ba = clamp32(p_ba + rnd24(d01 * dt));
		p_bb = clamp32(p_bb + rnd24(d11 * dt));
		if (has) begin
			e = p_aa + longint'(r_cfg);
			if (e > 0) begin
				err = clamp32(longint'(meas) - angle_q);
				k0 = gain_q24(p_aa, e);
				k1 = gain_q24(p_ba, e);
				t0 = p_aa;
				t1 = p_ab;
				p_aa = clamp32(p_aa - rnd24(k0 * t0));
				p_ab = clamp32(p_ab - rnd24(k0 * t1));
				p_ba = clamp32(p_ba - rnd24(k1 * t0));
				p_bb = clamp32(p_bb - rnd24(k1 * t1));
				bias_q = clamp32(bias_q + rnd24(k1 * err));
				angle_q = clamp32(angle_q + rnd24(k0 * err));
			end
		end
		est.angle_estimate = angle_q[31:0];
		est.unbiased_rate = rate[31:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		estimate_t est, got;
		int bad;
		if (!arst_n) begin
			dt_cfg = DT_RESET;
			r_cfg = R_RESET;
			qg_cfg = QG_RESET;
			qa_cfg = QA_RESET;
			angle_q = 0;
			bias_q = 0;
			p_aa = longint'(ONE_Q24);
			p_ab = 0;
			p_ba = 0;
			p_bb = longint'(ONE_Q24);
			expected_estimates.delete();
			fail_count <= 0;
			estimates_owed <= 0;
		end else begin
			bad = 0;
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					CFG_TIME_STEP:     dt_cfg = cfg_data;
					CFG_MEASURE_NOISE: r_cfg = cfg_data;
					CFG_GYRO_NOISE:    qg_cfg = cfg_data;
					CFG_ANGLE_NOISE:   qa_cfg = cfg_data;
					default: ;
				endcase
			end
			if (samples.valid && samples.ready) begin
				filter_step(samples.gyro_sample, samples.measured_angle,
					samples.has_measurement, est);
				expected_estimates.push_back(est);
			end
			if (results.valid && results.ready) begin
				if (expected_estimates.size() == 0) begin
					$display("%0t unexpected result: expected none actual angle %0d rate %0d",
						$time, results.angle_estimate, results.unbiased_rate);
					bad++;
				end else begin
					got = expected_estimates.pop_front();
					if (results.angle_estimate !== got.angle_estimate) begin
						$display("%0t angle_estimate mismatch: expected %0d actual %0d",
							$time, got.angle_estimate, results.angle_estimate);
						bad++;
					end
					if (results.unbiased_rate !== got.unbiased_rate) begin
						$display("%0t unbiased_rate mismatch: expected %0d actual %0d",
							$time, got.unbiased_rate, results.unbiased_rate);
						bad++;
					end
				end
			end
			fail_count <= fail_count + bad;
			estimates_owed <= expected_estimates.size();
		end
	end

endmodule

// ----- tb/sv/tilt_angle_kalman_filter_unit_tb.sv -----
// Top of the tilt angle Kalman filter unit testbench: clock, reset, config phases,
// directed and random samples with random idling on both channels, verdict.
// Depends on tkf_pkg, tkf_in_if, tkf_out_if, the unit and its checker.
module tilt_angle_kalman_filter_unit_tb;
	import tkf_pkg::*;

	localparam data_t MAX_Q16 = 32'sh7FFFFFFF;
	localparam data_t MIN_Q16 = 32'sh80000000;
	localparam cfg_t  CFG_MAX = 31'h7FFFFFFF;
	localparam int    WATCHDOG_LIMIT = 3000;
	localparam int    SETTLE_CYCLES  = 60;
	localparam int    RANDOM_PHASES  = 10;
	localparam int    PHASE_ITEMS    = 95;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	cfg_t                 cfg_data = '0;
	bit                   steady = 1'b0;
	int                   fail_count;
	int                   estimates_owed;
	int                   idle_cycles = 0;

	tkf_in_if  samples();
	tkf_out_if results();

	tilt_angle_kalman_filter_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.samples(samples),
		.results(results)
	);

	tilt_angle_kalman_filter_unit_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.samples(samples),
		.results(results),
		.fail_count(fail_count),
		.estimates_owed(estimates_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	function automatic data_t rand_q16();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return data_t'(int'($urandom_range(0, 524288)) - 262144);
			6:                return $urandom_range(0, 1) ? MAX_Q16 : MIN_Q16;
			default:          return data_t'($urandom());
		endcase
	endfunction

	function automatic cfg_t pick_cfg(input cfg_t nominal);
		case ($urandom_range(0, 9))
			0:          return '0;
			1:          return CFG_MAX;
			2, 3, 4, 5: return nominal;
			6, 7:       return cfg_t'($urandom_range(0, 2 * nominal + 1));
			default:    return cfg_t'($urandom());
		endcase
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input cfg_t val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_filter_config(input cfg_t dt, input cfg_t r, input cfg_t qg,
			input cfg_t qa);
		write_reg(CFG_TIME_STEP, dt);
		write_reg(CFG_MEASURE_NOISE, r);
		write_reg(CFG_GYRO_NOISE, qg);
		write_reg(CFG_ANGLE_NOISE, qa);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_sample(input data_t gyro, input data_t meas, input logic has);
		samples.valid <= 1'b1;
		samples.gyro_sample <= gyro;
		samples.measured_angle <= meas;
		samples.has_measurement <= has;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
	endtask

	task automatic idle_sender(input bit pause);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (pause || gap > 0) begin
			samples.valid <= 1'b0;
			if (pause) begin
				@(posedge clk);
				while (estimates_owed != 0)
					@(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic sample_then_idle(input data_t gyro, input data_t meas, input logic has);
		send_sample(gyro, meas, has);
		idle_sender(1'b0);
	endtask

	task automatic drain(input int settle);
		samples.valid <= 1'b0;
		@(posedge clk);
		while (estimates_owed != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples.valid && samples.ready) || (results.valid && results.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL tilt_angle_kalman_filter_unit");
				$finish;
			end
		end
	end

	initial begin : sink_side
		int burst, gap;
		results.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			results.ready <= 1'b1;
			burst = $urandom_range(1, 20);
			repeat (burst) @(posedge clk);
			gap = steady ? 0 : pick_gap();
			if (gap > 0) begin
				results.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin : source_side
		bit pause;
		samples.valid = 1'b0;
		samples.gyro_sample = '0;
		samples.measured_angle = '0;
		samples.has_measurement = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: field extremes, predict only and with update
		sample_then_idle('0, '0, 1'b0);
		sample_then_idle(MAX_Q16, '0, 1'b0);
		sample_then_idle(MIN_Q16, '0, 1'b0);
		sample_then_idle(-32'sd1, '0, 1'b1);
		sample_then_idle('0, MAX_Q16, 1'b1);
		sample_then_idle('0, MIN_Q16, 1'b1);
		sample_then_idle(32'sd1, -32'sd1, 1'b1);
		sample_then_idle(MAX_Q16, MAX_Q16, 1'b1);
		sample_then_idle(MIN_Q16, MIN_Q16, 1'b1);
		drain(2);

		// zero dt and R: covariance collapses, then the update is skipped
		set_filter_config('0, '0, QG_RESET, QA_RESET);
		repeat (3) sample_then_idle(32'sd100, 32'sd65536, 1'b1);
		drain(2);

		// all registers at full scale
		set_filter_config(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
		sample_then_idle(MAX_Q16, MIN_Q16, 1'b1);
		sample_then_idle(MIN_Q16, MAX_Q16, 1'b0);
		sample_then_idle(32'sd12345, -32'sd54321, 1'b1);
		drain(2);

		// large dt without noise drives covariance through saturation and sign flips
		set_filter_config(CFG_MAX, '0, '0, '0);
		for (int i = 0; i < 6; i++)
			sample_then_idle(i[0] ? MIN_Q16 : 32'sd70000, i[0] ? 32'sd300000 : MIN_Q16, 1'b1);
		drain(2);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			steady = ($urandom_range(0, 3) == 0);
			if (ph == 0)
				set_filter_config(DT_RESET, R_RESET, QG_RESET, QA_RESET);
			else
				set_filter_config(pick_cfg(DT_RESET), pick_cfg(R_RESET),
					pick_cfg(QG_RESET), pick_cfg(QA_RESET));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_sample(rand_q16(), rand_q16(), 1'($urandom_range(0, 1)));
				pause = (ph == 0 && i == 10) || ($urandom_range(0, 39) == 0);
				idle_sender(pause);
			end
			drain(2);
		end

		steady = 1'b0;
		drain(SETTLE_CYCLES);
		if (fail_count == 0)
			$display("PASS tilt_angle_kalman_filter_unit");
		else
			$display("FAIL tilt_angle_kalman_filter_unit");
		$finish;
	end

endmodule
